// File: rtl/lwc_pkg.sv
// Package for the LZ77 window copy engine: request and result transaction
// types, state encoding, window control struct and shared constants.
// No dependencies.
`default_nettype none

package lwc_pkg;

  localparam int WIN_SIZE_DEF = 32768;  // default window size in bytes
  localparam int LANES        = 8;      // bytes per result and per window access
  localparam int HIST_DEPTH   = 16;     // recent bytes held in flops

  localparam logic [8:0] MAX_COPY_LEN = 9'd258;

  localparam logic REQ_LIT  = 1'b0;
  localparam logic REQ_COPY = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  literal_byte;
    logic [15:0] distance;
    logic [8:0]  length;
  } req_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [3:0] wr_count;
  } win_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_FETCH,
    ST_COPY
  } lwc_state_e;

endpackage

`default_nettype wire

// File: rtl/lwc_bank_ram.sv
// One byte-wide bank of the history window: one write port, one read port,
// registered read data. Depends on nothing.
`default_nettype none

module lwc_bank_ram #(
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read during write of the same row returns the old byte
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/lwc_window.sv
// History window built from eight interleaved byte banks, so that eight
// consecutive addresses are read or written in a single access at any alignment.
// Depends on lwc_pkg and lwc_bank_ram.
`default_nettype none

module lwc_window #(
  parameter int WindowSize = lwc_pkg::WIN_SIZE_DEF,
  localparam int AddrW = $clog2(WindowSize)
) (
  input  wire logic             clk_i,
  input  wire lwc_pkg::win_ctrl_t ctrl_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [63:0]      wr_data_i,
  output logic      [63:0]      rd_data_o
);

  import lwc_pkg::*;

  localparam int Rows = WindowSize / LANES;

  logic [7:0] bank_rd [LANES];
  logic [2:0] rd_lo_q;

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [2:0]       roff;
    logic [2:0]       woff;
    logic [AddrW-1:0] raddr;
    logic [AddrW-1:0] waddr;
    logic             we;

    // lane that lands in this bank, relative to the start address
    assign roff  = 3'(b) - rd_addr_i[2:0];
    assign raddr = rd_addr_i + AddrW'(roff);
    assign woff  = 3'(b) - wr_addr_i[2:0];
    assign waddr = wr_addr_i + AddrW'(woff);
    assign we    = ctrl_i.wr_en && ({1'b0, woff} < ctrl_i.wr_count);

    lwc_bank_ram #(
      .Depth(Rows)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr[AddrW-1:3]),
      .wdata_i(wr_data_i[8*woff +: 8]),
      .re_i   (ctrl_i.rd_en),
      .raddr_i(raddr[AddrW-1:3]),
      .rdata_o(bank_rd[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_lo_q <= rd_addr_i[2:0];
    end
  end

  // rotate bank outputs back into lane order
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rd_data_o[8*j +: 8] = bank_rd[3'(rd_lo_q + 3'(j))];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lz77_window_copy_engine_top.sv
// Top level of the LZ77 window copy engine: request FSM, byte assembly,
// recent-byte history and write pointer. Depends on lwc_pkg and lwc_window.
//
// Usage: a request transaction (literal or back-reference copy) is taken on
// a rising edge with start high and busy low. Results leave on result_o with
// result_valid_o high for exactly one cycle each; the receiver cannot stall,
// so every result must be taken when shown.
// A literal gives one result with one byte. A copy, length saturated to 258,
// gives ceil(length/8) results, one per cycle, the last one flagged is_last.
// A literal result passes through the ST_LIT state and the result register;
// the first result of a copy passes ST_FETCH, ST_COPY and the result register.
// A copy first reads the banks in ST_FETCH and then moves up to eight bytes
// per cycle through the eight-bank window in ST_COPY. busy drops in the final
// emit cycle, so back-to-back requests follow without a gap.
// Copies shorter than 16 bytes back are served from a 16-byte flop history,
// longer ones from the banks. Reset clears the write pointer, the fill count
// and the history; the banks are not swept: bytes never written read as
// zero through the fill count.
`default_nettype none

module lz77_window_copy_engine_top #(
  parameter int WindowSize = lwc_pkg::WIN_SIZE_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire lwc_pkg::req_t req_i,
  output logic               busy,
  output lwc_pkg::res_t      result_o,
  output logic               result_valid_o
);

  import lwc_pkg::*;

  localparam int AddrW = $clog2(WindowSize);

  function automatic logic [3:0] mod_small(logic [3:0] j, logic [3:0] d);
    logic [3:0] r;
    r = j;
    for (int i = 0; i < LANES - 1; i++) begin
      if (r >= d) begin
        r = r - d;
      end
    end
    return r;
  endfunction

  lwc_state_e state_q, state_d, new_state;

  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW:0]   filled_q, filled_d;
  logic [7:0]       hist_q [HIST_DEPTH];
  logic [7:0]       hist_d [HIST_DEPTH];
  logic [8:0]       emit_left_q;
  logic [7:0]       lit_q;
  logic [AddrW:0]   d_q;
  logic             small_q;
  logic [AddrW-1:0] rd_q;
  res_t             res_q;
  logic             res_valid_q;

  logic             accept;
  logic [8:0]       len_sat;
  logic [AddrW-1:0] d_mod;
  logic [AddrW:0]   d_eff;
  logic [AddrW-1:0] rd0;
  logic             rd_en;
  logic             emit;
  logic [3:0]       copy_cnt;
  logic             grp_last;
  logic [3:0]       emit_cnt;
  logic             emit_last;
  logic [7:0]       eb [LANES];
  logic [63:0]      emit_bytes;
  logic [63:0]      mem_bytes;
  logic [AddrW+1:0] fill_sum;
  win_ctrl_t        win_ctrl;

  // ---------------------------------------------------------------- request
  assign accept  = start && !busy;
  assign len_sat = (req_i.length > MAX_COPY_LEN) ? MAX_COPY_LEN : req_i.length;
  assign d_mod   = req_i.distance[AddrW-1:0];
  assign d_eff   = (d_mod == '0) ? (AddrW+1)'(WindowSize) : {1'b0, d_mod};
  assign rd0     = wp_d - d_mod;

  always_comb begin
    if (req_i.req_type == REQ_LIT) begin
      new_state = ST_LIT;
    end else if (len_sat == '0) begin
      new_state = ST_IDLE;
    end else begin
      new_state = ST_FETCH;
    end
  end

  assign copy_cnt = (emit_left_q >= 9'd8) ? 4'd8 : emit_left_q[3:0];
  assign grp_last = (emit_left_q <= 9'd8);

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = new_state;
      end
      ST_LIT: begin
        state_d = accept ? new_state : ST_IDLE;
      end
      ST_FETCH: begin
        state_d = ST_COPY;
      end
      ST_COPY: begin
        if (grp_last) state_d = accept ? new_state : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    rd_en     = 1'b0;
    emit      = 1'b0;
    emit_cnt  = copy_cnt;
    emit_last = grp_last;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_LIT: begin
        busy      = 1'b0;
        emit      = 1'b1;
        emit_cnt  = 4'd1;
        emit_last = 1'b1;
      end
      ST_FETCH: begin
        rd_en = 1'b1;
      end
      ST_COPY: begin
        busy  = !grp_last;
        rd_en = 1'b1;
        emit  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------- window
  always_comb begin
    win_ctrl.rd_en    = rd_en;
    win_ctrl.wr_en    = emit;
    win_ctrl.wr_count = emit_cnt;
  end

  lwc_window #(
    .WindowSize(WindowSize)
  ) u_window (
    .clk_i    (clk_i),
    .ctrl_i   (win_ctrl),
    .rd_addr_i(rd_q),
    .wr_addr_i(wp_q),
    .wr_data_i(emit_bytes),
    .rd_data_o(mem_bytes)
  );

  // ---------------------------------------------------------------- bytes
  // Short distances repeat bytes of the last 16 written; take them from the
  // history flops. Long ones come from the banks, masked to zero where the
  // window was never filled that far back.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (state_q == ST_LIT) begin
        eb[j] = (j == 0) ? lit_q : 8'd0;
      end else if (small_q) begin
        eb[j] = hist_q[d_q[3:0] - 4'd1 - mod_small(4'(j), d_q[3:0])];
      end else if ({1'b0, d_q} <= ({1'b0, filled_q} + (AddrW+2)'(j))) begin
        eb[j] = mem_bytes[8*j +: 8];
      end else begin
        eb[j] = 8'd0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      emit_bytes[8*j +: 8] = (4'(j) < emit_cnt) ? eb[j] : 8'd0;
    end
  end

  // ---------------------------------------------------------------- state
  assign fill_sum = {1'b0, filled_q} + (AddrW+2)'(emit_cnt);

  always_comb begin
    wp_d     = wp_q;
    filled_d = filled_q;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (emit) begin
      wp_d     = wp_q + AddrW'(emit_cnt);
      filled_d = (fill_sum > (AddrW+2)'(WindowSize)) ? (AddrW+1)'(WindowSize)
                                                      : fill_sum[AddrW:0];
      // shift the new bytes in, most recent at entry zero
      for (int i = 0; i < HIST_DEPTH; i++) begin
        if (4'(i) < emit_cnt) begin
          hist_d[i] = eb[3'(emit_cnt - 4'd1 - 4'(i))];
        end else begin
          hist_d[i] = hist_q[4'(i) - emit_cnt];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      filled_q    <= '0;
      emit_left_q <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      filled_q    <= filled_d;
      res_valid_q <= emit;
      hist_q      <= hist_d;
      if (accept) begin
        emit_left_q <= len_sat;
      end else if (emit) begin
        emit_left_q <= emit_left_q - 9'(emit_cnt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lit_q   <= req_i.literal_byte;
      d_q     <= d_eff;
      small_q <= (d_eff < (AddrW+1)'(HIST_DEPTH));
      rd_q    <= rd0;
    end else if (rd_en) begin
      rd_q <= rd_q + AddrW'(LANES);
    end
    if (emit) begin
      res_q.out_bytes  <= emit_bytes;
      res_q.byte_count <= emit_cnt;
      res_q.is_last    <= emit_last;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  // ---------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.byte_count != 4'd0) && (result_o.byte_count <= 4'd8))
    else $error("result byte count out of range");

  a_full_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.is_last) |-> (result_o.byte_count == 4'd8))
    else $error("partial result before the end of a copy");

  a_copy_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.is_last) |=> result_valid_o)
    else $error("copy results not contiguous");

  a_fetch_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_COPY))
    else $error("fetch not followed by copy");

endmodule

`default_nettype wire

// File: dv/tb_lz77_window_copy_engine_top.sv
// Testbench for lz77_window_copy_engine_top: drives literal and copy requests,
// predicts the packed byte results from a private window copy and checks them.
// Depends on lwc_pkg and the RTL of the engine.
module tb_lz77_window_copy_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WinSize     = lwc_pkg::WIN_SIZE_DEF;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int RandomItems = 450;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  lwc_pkg::req_t req_i  = '0;
  logic          busy;
  lwc_pkg::res_t result_o;
  logic          result_valid_o;

  lwc_pkg::req_t pending_reqs[$];
  lwc_pkg::res_t expected_chunks[$];
  lwc_pkg::res_t want;

  logic [7:0]  hist_mem [WinSize];
  int unsigned wr_ptr         = 0;
  int          burst_left     = 1;
  int          gap_left       = 0;
  int          accepted_count = 0;
  int          total_items    = 0;
  int          err_count      = 0;
  int          cycle_count    = 0;

  lz77_window_copy_engine_top #(
    .WindowSize(WinSize)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_i         (req_i),
    .busy          (busy),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Play one request into the shadow window and queue the chunks it yields.
  task automatic expand_request(input lwc_pkg::req_t r);
    int unsigned   n;
    int unsigned   rd;
    int unsigned   fill;
    int unsigned   i;
    logic [7:0]    b;
    lwc_pkg::res_t chunk;
    chunk = '0;
    if (r.req_type == lwc_pkg::REQ_LIT) begin
      hist_mem[wr_ptr] = r.literal_byte;
      wr_ptr = (wr_ptr + 1) % WinSize;
      chunk.out_bytes  = {56'd0, r.literal_byte};
      chunk.byte_count = 4'd1;
      chunk.is_last    = 1'b1;
      expected_chunks.push_back(chunk);
    end else begin
      n = r.length;
      if (n > lwc_pkg::MAX_COPY_LEN) n = lwc_pkg::MAX_COPY_LEN;
      rd   = (wr_ptr + WinSize - (r.distance % WinSize)) % WinSize;
      fill = 0;
      for (i = 0; i < n; i++) begin
        b = hist_mem[rd];
        hist_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % WinSize;
        rd = (rd + 1) % WinSize;
        chunk.out_bytes[8*fill +: 8] = b;
        fill++;
        if (fill == lwc_pkg::LANES || i + 1 == n) begin
          chunk.byte_count = 4'(fill);
          chunk.is_last    = (i + 1 == n);
          expected_chunks.push_back(chunk);
          chunk = '0;
          fill  = 0;
        end
      end
    end
  endtask

  // Ignored fields carry random bits.
  task automatic queue_literal(input logic [7:0] lit);
    lwc_pkg::req_t r;
    r.req_type     = lwc_pkg::REQ_LIT;
    r.literal_byte = lit;
    r.distance     = 16'($urandom);
    r.length       = 9'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_copy(input int unsigned copy_dist, input int unsigned len);
    lwc_pkg::req_t r;
    r.req_type     = lwc_pkg::REQ_COPY;
    r.literal_byte = 8'($urandom);
    r.distance     = 16'(copy_dist);
    r.length       = 9'(len);
    pending_reqs.push_back(r);
  endtask

  // Driver: hold the current transaction until taken, then issue in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        expand_request(req_i);
        accepted_count++;
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 50);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 25)
                                                     : $urandom_range(1, 4);
          end
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected chunk.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_chunks.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, result_o);
        err_count++;
      end else begin
        want = expected_chunks.pop_front();
        if (result_o.out_bytes !== want.out_bytes) begin
          $display("%0t: out_bytes mismatch: expected %h, actual %h",
                   $time, want.out_bytes, result_o.out_bytes);
          err_count++;
        end
        if (result_o.byte_count !== want.byte_count) begin
          $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                   $time, want.byte_count, result_o.byte_count);
          err_count++;
        end
        if (result_o.is_last !== want.is_last) begin
          $display("%0t: is_last mismatch: expected %b, actual %b",
                   $time, want.is_last, result_o.is_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned copy_dist;
    int unsigned len;
    int          k;

    foreach (hist_mem[j]) hist_mem[j] = 8'd0;

    // Directed: byte extremes, zero and wrapped distances, overlap, length edges.
    queue_literal(8'h00);
    queue_literal(8'hFF);
    queue_literal(8'hA5);
    queue_copy(0, 1);         // distance zero reads the oldest, unwritten byte
    queue_copy(1, 1);
    queue_copy(1, 20);        // overlapping copy repeats the last byte
    queue_copy(3, 258);
    queue_copy(5, 0);         // zero length yields nothing
    queue_copy(2, 511);       // saturate to the maximum length
    queue_copy(16, 8);
    queue_copy(17, 9);
    queue_copy(15, 16);
    queue_copy(8, 8);
    queue_copy(32768, 10);
    queue_copy(65535, 7);     // wraps to one less than the window
    queue_copy(40000, 33);
    queue_literal(8'h5A);
    queue_copy(300, 259);
    queue_literal(8'h3C);
    queue_copy(1, 258);

    for (k = 0; k < RandomItems; k++) begin
      if ($urandom_range(0, 99) < 40) begin
        queue_literal(8'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 3)       len = 0;
        else if (sel < 40) len = $urandom_range(1, 16);
        else if (sel < 58) len = $urandom_range(17, 64);
        else if (sel < 95) len = $urandom_range(200, 258);
        else               len = $urandom_range(259, 511);
        sel = $urandom_range(0, 99);
        if (sel < 40)      copy_dist = $urandom_range(1, 16);
        else if (sel < 70) copy_dist = $urandom_range(17, 300);
        else if (sel < 90) copy_dist = $urandom_range(301, 32768);
        else if (sel < 95) copy_dist = $urandom_range(32769, 65535);
        else begin
          case ($urandom_range(0, 4))
            0:       copy_dist = 0;
            1:       copy_dist = 32768;
            2:       copy_dist = 15;
            3:       copy_dist = 16;
            default: copy_dist = 17;
          endcase
        end
        queue_copy(copy_dist, len);
      end
    end
    total_items = pending_reqs.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_count == total_items);
    wait (expected_chunks.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
